// ----- design/csvt_pkg.sv -----
// shared types, constants and codes of the csv record tokenizer
package csvt_pkg;

  localparam int unsigned LINE_W = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] BOM_B0   = 8'hEF;
  localparam logic [7:0] BOM_B1   = 8'hBB;
  localparam logic [7:0] BOM_B2   = 8'hBF;

  typedef enum logic {
    OP_BYTE,
    OP_END
  } op_e;

  typedef enum logic [1:0] {
    CFG_COL_LIMIT,
    CFG_ROW_LIMIT,
    CFG_BYTE_LIMIT
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BOM_START,
    BOM_EF,
    BOM_EFBB,
    BOM_DONE
  } bom_e;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_QUOTE_SEEN,
    MODE_CLOSED
  } mode_e;

  typedef enum logic [1:0] {
    CRP_NONE,
    CRP_SKIP_LF,
    CRP_QUOTED_LF
  } crp_e;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_FIELD_END,
    KIND_RECORD_END,
    KIND_ERROR
  } kind_e;

  typedef enum logic [3:0] {
    ERR_HEADER,
    ERR_SHAPE,
    ERR_ROWS,
    ERR_BYTES,
    ERR_NUL,
    ERR_AFTER_QUOTE,
    ERR_STRAY_QUOTE,
    ERR_COLUMNS,
    ERR_OPEN_QUOTE,
    ERR_NO_HEADER
  } err_e;

  typedef struct packed {
    logic [9:0]  col_limit;
    logic [31:0] row_limit;
    logic [31:0] byte_limit;
  } cfg_t;

  typedef struct packed {
    bom_e              bom;
    mode_e             mode;
    logic              fld_open;
    logic              nonempty;
    crp_e              crp;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] rec_line;
    logic [10:0]       cols;
    logic [10:0]       hdr_w;
    logic              hdr_empty;
    logic [31:0]       rows;
    logic [31:0]       bytes;
    logic              failed;
  } st_t;

  localparam st_t ST_RESET = '{
    bom:       BOM_START,
    mode:      MODE_PLAIN,
    fld_open:  1'b0,
    nonempty:  1'b0,
    crp:       CRP_NONE,
    line:      LINE_W'(1),
    rec_line:  LINE_W'(1),
    cols:      11'd0,
    hdr_w:     11'd0,
    hdr_empty: 1'b0,
    rows:      32'd0,
    bytes:     32'd0,
    failed:    1'b0
  };

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  field_byte;
    logic        is_header;
    logic [31:0] row_index;
    logic [31:0] first_line;
    logic [31:0] last_line;
    logic [10:0] field_count;
    err_e        error_code;
  } res_t;

  // results of one request: replayed mark bytes first, then at most one parsed result
  typedef struct packed {
    logic [1:0] rep_cnt;
    logic       vld;
    res_t       res;
  } batch_t;

endpackage

// ----- design/csvt_core.sv -----
// parser state and single-pass step logic of the csv record tokenizer
module csvt_core
  import csvt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  op_e        op_i,
  input  logic [7:0] byte_i,
  input  cfg_t       cfg_i,
  output batch_t     batch_o
);

  typedef struct packed {
    st_t  st;
    logic vld;
    res_t res;
    logic ok;
  } ev_t;

  st_t        state_q;
  st_t        state_d;
  ev_t        e;
  logic       do_parse;
  logic [1:0] rep;

  function automatic res_t emit(st_t s, kind_e k, logic [7:0] b, err_e code);
    res_t r;
    r.kind        = k;
    r.field_byte  = b;
    r.is_header   = (s.hdr_w == 11'd0);
    r.row_index   = s.rows;
    r.first_line  = 32'(s.rec_line);
    r.last_line   = 32'(s.line);
    r.field_count = s.cols;
    r.error_code  = code;
    return r;
  endfunction

  function automatic ev_t quiet(st_t s);
    ev_t r;
    r.st  = s;
    r.vld = 1'b0;
    r.res = '0;
    r.ok  = 1'b1;
    return r;
  endfunction

  function automatic ev_t raise(st_t s, err_e code);
    ev_t r;
    r.st        = s;
    r.st.failed = 1'b1;
    r.vld       = 1'b1;
    r.res       = emit(s, KIND_ERROR, 8'h00, code);
    r.ok        = 1'b0;
    return r;
  endfunction

  // ERR_HEADER stands for the zero code of non-error results
  function automatic ev_t content(st_t s, logic [7:0] c);
    ev_t r;
    r          = quiet(s);
    r.st.nonempty = 1'b1;
    r.vld      = 1'b1;
    r.res      = emit(r.st, KIND_BYTE, c, ERR_HEADER);
    return r;
  endfunction

  function automatic st_t bump_line(st_t s);
    st_t r;
    r = s;
    if (s.line != {LINE_W{1'b1}}) begin
      r.line = s.line + LINE_W'(1);
    end
    return r;
  endfunction

  function automatic st_t end_field(st_t s);
    st_t r;
    r = s;
    if (s.cols != 11'h7ff) begin
      r.cols = s.cols + 11'd1;
    end
    if (s.hdr_w == 11'd0 && !s.nonempty) begin
      r.hdr_empty = 1'b1;
    end
    r.fld_open = 1'b0;
    r.nonempty = 1'b0;
    r.mode     = MODE_PLAIN;
    return r;
  endfunction

  function automatic ev_t on_comma(st_t s, cfg_t cfg);
    ev_t  r;
    st_t  t;
    t = end_field(s);
    if (t.cols > {1'b0, cfg.col_limit}) begin
      r = raise(t, ERR_COLUMNS);
    end else begin
      r     = quiet(t);
      r.vld = 1'b1;
      r.res = emit(t, KIND_FIELD_END, 8'h00, ERR_HEADER);
    end
    return r;
  endfunction

  function automatic ev_t close_rec(st_t s, cfg_t cfg);
    ev_t r;
    st_t t;
    t = end_field(s);
    if (t.hdr_w == 11'd0) begin
      if (t.cols > {1'b0, cfg.col_limit} || t.hdr_empty) begin
        r = raise(t, ERR_HEADER);
      end else begin
        r          = quiet(t);
        r.vld      = 1'b1;
        r.res      = emit(t, KIND_RECORD_END, 8'h00, ERR_HEADER);
        r.st.hdr_w = t.cols;
        r.st.cols  = 11'd0;
      end
    end else if (t.cols != t.hdr_w) begin
      r = raise(t, ERR_SHAPE);
    end else if (t.rows >= cfg.row_limit) begin
      r = raise(t, ERR_ROWS);
    end else begin
      r         = quiet(t);
      r.vld     = 1'b1;
      r.res     = emit(t, KIND_RECORD_END, 8'h00, ERR_HEADER);
      r.st.rows = t.rows + 32'd1;
      r.st.cols = 11'd0;
    end
    return r;
  endfunction

  function automatic ev_t on_line_end(st_t s, logic [7:0] c, cfg_t cfg);
    ev_t r;
    r = close_rec(s, cfg);
    if (r.ok) begin
      r.st          = bump_line(r.st);
      r.st.rec_line = r.st.line;
      r.st.crp      = (c == CH_CR) ? CRP_SKIP_LF : CRP_NONE;
    end
    return r;
  endfunction

  function automatic ev_t parse_byte(st_t s, logic [7:0] c, cfg_t cfg);
    ev_t  r;
    crp_e pend;
    logic done;
    r      = quiet(s);
    pend   = s.crp;
    done   = 1'b0;
    r.st.crp = CRP_NONE;
    if (c == CH_LF && pend == CRP_SKIP_LF) begin
      done = 1'b1;
    end else if (c == CH_LF && pend == CRP_QUOTED_LF && s.mode == MODE_QUOTED) begin
      r    = content(r.st, c);
      done = 1'b1;
    end else if (s.mode == MODE_QUOTE_SEEN) begin
      if (c == CH_QUOTE) begin
        r         = content(r.st, c);
        r.st.mode = MODE_QUOTED;
        done      = 1'b1;
      end else begin
        r.st.mode = MODE_CLOSED;
      end
    end
    if (!done) begin
      case (r.st.mode)
        MODE_QUOTED: begin
          if (c == CH_QUOTE) begin
            r.st.mode = MODE_QUOTE_SEEN;
          end else if (c == CH_CR) begin
            r        = content(r.st, c);
            r.st     = bump_line(r.st);
            r.st.crp = CRP_QUOTED_LF;
          end else begin
            r = content(r.st, c);
            if (c == CH_LF) begin
              r.st = bump_line(r.st);
            end
          end
        end
        MODE_CLOSED: begin
          if (c == CH_COMMA) begin
            r = on_comma(r.st, cfg);
          end else if (c == CH_CR || c == CH_LF) begin
            r = on_line_end(r.st, c, cfg);
          end else begin
            r = raise(r.st, ERR_AFTER_QUOTE);
          end
        end
        default: begin
          if (c == CH_QUOTE) begin
            if (!r.st.fld_open) begin
              r.st.mode     = MODE_QUOTED;
              r.st.fld_open = 1'b1;
            end else begin
              r = raise(r.st, ERR_STRAY_QUOTE);
            end
          end else if (c == CH_COMMA) begin
            r = on_comma(r.st, cfg);
          end else if (c == CH_CR || c == CH_LF) begin
            r = on_line_end(r.st, c, cfg);
          end else begin
            r.st.fld_open = 1'b1;
            r = content(r.st, c);
          end
        end
      endcase
    end
    return r;
  endfunction

  // replayed mark bytes land in a fresh plain field as content
  function automatic st_t replay(st_t s);
    st_t r;
    r          = s;
    r.fld_open = 1'b1;
    r.nonempty = 1'b1;
    r.crp      = CRP_NONE;
    return r;
  endfunction

  function automatic ev_t end_input(st_t s, cfg_t cfg);
    ev_t r;
    r        = quiet(s);
    r.st.crp = CRP_NONE;
    if (r.st.mode == MODE_QUOTE_SEEN) begin
      r.st.mode = MODE_CLOSED;
    end
    if (r.st.mode == MODE_QUOTED) begin
      r = raise(r.st, ERR_OPEN_QUOTE);
    end else if (r.st.mode == MODE_CLOSED || r.st.fld_open || r.st.cols != 11'd0 ||
                 r.st.nonempty) begin
      r = close_rec(r.st, cfg);
    end else if (r.st.hdr_w == 11'd0) begin
      r = raise(r.st, ERR_NO_HEADER);
    end
    return r;
  endfunction

  always_comb begin
    e        = quiet(state_q);
    do_parse = 1'b0;
    rep      = 2'd0;
    if (!state_q.failed) begin
      if (op_i == OP_END) begin
        if (e.st.bom == BOM_EF || e.st.bom == BOM_EFBB) begin
          rep  = (e.st.bom == BOM_EFBB) ? 2'd2 : 2'd1;
          e.st = replay(e.st);
        end
        e.st.bom = BOM_DONE;
        e        = end_input(e.st, cfg_i);
      end else if (e.st.bytes >= cfg_i.byte_limit) begin
        e = raise(e.st, ERR_BYTES);
      end else begin
        e.st.bytes = e.st.bytes + 32'd1;
        if (byte_i == CH_NUL) begin
          e = raise(e.st, ERR_NUL);
        end else begin
          case (e.st.bom)
            BOM_START: begin
              if (byte_i == BOM_B0) begin
                e.st.bom = BOM_EF;
              end else begin
                e.st.bom = BOM_DONE;
                do_parse = 1'b1;
              end
            end
            BOM_EF: begin
              if (byte_i == BOM_B1) begin
                e.st.bom = BOM_EFBB;
              end else begin
                rep      = 2'd1;
                e.st     = replay(e.st);
                e.st.bom = BOM_DONE;
                do_parse = 1'b1;
              end
            end
            BOM_EFBB: begin
              if (byte_i == BOM_B2) begin
                e.st.bom = BOM_DONE;
              end else begin
                rep      = 2'd2;
                e.st     = replay(e.st);
                e.st.bom = BOM_DONE;
                do_parse = 1'b1;
              end
            end
            default: begin
              do_parse = 1'b1;
            end
          endcase
        end
      end
    end
    if (do_parse) begin
      e = parse_byte(e.st, byte_i, cfg_i);
    end
    state_d         = e.st;
    batch_o.rep_cnt = rep;
    batch_o.vld     = e.vld;
    batch_o.res     = e.res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RESET;
    end else if (load_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/csvt_out.sv -----
// result register that hands out the results of one request one per cycle while the receiver is ready
module csvt_out
  import csvt_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   load_i,
  input  batch_t batch_i,
  input  logic   ready_i,
  output logic   valid_o,
  output logic   last_o,
  output res_t   res_o
);

  logic [1:0] rep_cnt_q;
  logic       rep_bb_q;
  logic       main_vld_q;
  res_t       main_q;
  res_t       rep_res;

  // mark bytes only replay at stream start, so their context is the reset one
  always_comb begin
    rep_res.kind        = KIND_BYTE;
    rep_res.field_byte  = rep_bb_q ? BOM_B1 : BOM_B0;
    rep_res.is_header   = 1'b1;
    rep_res.row_index   = ST_RESET.rows;
    rep_res.first_line  = 32'(ST_RESET.rec_line);
    rep_res.last_line   = 32'(ST_RESET.line);
    rep_res.field_count = ST_RESET.cols;
    rep_res.error_code  = ERR_HEADER;
  end

  assign valid_o = (rep_cnt_q != 2'd0) || main_vld_q;
  assign last_o  = (rep_cnt_q == 2'd1 && !main_vld_q) || (rep_cnt_q == 2'd0 && main_vld_q);
  assign res_o   = (rep_cnt_q != 2'd0) ? rep_res : main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_cnt_q  <= 2'd0;
      rep_bb_q   <= 1'b0;
      main_vld_q <= 1'b0;
    end else if (load_i) begin
      rep_cnt_q  <= batch_i.rep_cnt;
      rep_bb_q   <= 1'b0;
      main_vld_q <= batch_i.vld;
    end else if (valid_o && ready_i) begin
      if (rep_cnt_q != 2'd0) begin
        rep_cnt_q <= rep_cnt_q - 2'd1;
        rep_bb_q  <= 1'b1;
      end else begin
        main_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      main_q <= batch_i.res;
    end
  end

endmodule

// ----- design/csv_record_tokenizer_top.sv -----
// top level of the csv record tokenizer: input register, config registers, core, result stage
//
// CSV tokenizer that takes one request per cycle while the output is ready: a source byte or
// an end-of-input marker (tuser bit 0 set). Each request goes from the input register through
// one pass of parse logic into the result register, and waits in the input register until
// the result register is empty or its last result leaves. Requests that yield at most one
// result stream at one per cycle while the output is ready; a request that yields k results
// stalls the input side while the result register hands them out one per cycle, which only
// happens when a partial byte-order mark is replayed as data (up to three results). The first
// record is the header; the first error is reported with tlast set and afterwards the block
// drops every request silently until reset. Limits are to be written on the cfg port while
// idle; the block does not enforce this. There is no clearing pass after reset.
module csv_record_tokenizer_top
  import csvt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write port
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // source_byte
  input  logic [0:0]   s_axis_tuser,   // operation
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // field_byte, row_index, first_line, last_line, field_count, error_code, zero pad
  output logic [119:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser,   // kind, is_header
  output logic         m_axis_tlast
);

  // config registers
  cfg_t cfg_q;

  // input register
  logic       in_vld_q;
  op_e        in_op_q;
  logic [7:0] in_byte_q;

  logic   load;
  logic   out_last;
  batch_t batch;
  res_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.col_limit  <= 10'd256;
      cfg_q.row_limit  <= 32'd1000000;
      cfg_q.byte_limit <= 32'd67108864;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COL_LIMIT:  cfg_q.col_limit  <= cfg_data_i[9:0];
        CFG_ROW_LIMIT:  cfg_q.row_limit  <= cfg_data_i;
        CFG_BYTE_LIMIT: cfg_q.byte_limit <= cfg_data_i;
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

  // the held request moves on once the result register is empty or its last result leaves
  assign load          = in_vld_q && (!m_axis_tvalid || (m_axis_tready && out_last));
  assign s_axis_tready = !in_vld_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (load) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= op_e'(s_axis_tuser[0]);
      in_byte_q <= s_axis_tdata;
    end
  end

  csvt_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .op_i    (in_op_q),
    .byte_i  (in_byte_q),
    .cfg_i   (cfg_q),
    .batch_o (batch)
  );

  csvt_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .batch_i (batch),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .last_o  (out_last),
    .res_o   (res)
  );

  assign m_axis_tlast = out_last;
  assign m_axis_tuser = {res.is_header, res.kind};
  assign m_axis_tdata = {1'b0, res.error_code, res.field_count, res.last_line,
                         res.first_line, res.row_index, res.field_byte};

`ifndef SYNTHESIS
  // an error ends its request and nothing follows it until reset
  a_error_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser[1:0] == KIND_ERROR)
    |-> m_axis_tlast)
    else $error("error result not marked last");

  a_silent_after_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser[1:0] == KIND_ERROR)
    |=> !m_axis_tvalid)
    else $error("result after error");

  a_batch_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (batch.vld || batch.rep_cnt != 2'd0)) |=> m_axis_tvalid)
    else $error("loaded results not presented");

  a_record_has_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1:0] == KIND_RECORD_END) |-> (m_axis_tdata[114:104] != 11'd0))
    else $error("record end with no fields");
`endif

endmodule
